// ===== rtl/core/dqs_pkg.sv =====
// Shared types and constants for the deque with search.
// Holds operation codes, status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package dqs_pkg;

  localparam int DQS_DEPTH_DEFAULT = 1024;

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SRCH
  } ctrl_state_t;

  typedef struct packed {
    logic       push_back;
    logic       push_front;
    logic       pop_front;
    logic       pop_back;
    logic       srch_load;
    logic       srch_run;
    logic       finish;
    logic       take_rd;
    logic       take_hit;
    logic [1:0] res_status;
  } dqs_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic srch_done;
  } dqs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/dqs_ctrl.sv =====
// Controller state machine for the deque with search.
// Decodes each word into datapath commands; depends on dqs_pkg.
`default_nettype none

module dqs_ctrl
  import dqs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] func,
  input  wire dqs_sts_t   sts,
  output dqs_cmd_t        cmd,
  output logic            busy
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (func)
            OP_PUSH_BACK: begin
              cmd.finish = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.push_back = 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              cmd.finish = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.push_front = 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (sts.empty) begin
                cmd.finish     = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.pop_front = 1'b1;
                state_next    = S_POP;
              end
            end
            OP_POP_BACK: begin
              cmd.finish = 1'b1;
              if (sts.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.pop_back = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (sts.empty) begin
                cmd.finish     = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.srch_load = 1'b1;
                state_next    = S_SRCH;
              end
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.finish  = 1'b1;
        cmd.take_rd = 1'b1;
        state_next  = S_IDLE;
      end
      S_SRCH: begin
        cmd.srch_run = 1'b1;
        if (sts.srch_done) begin
          cmd.finish   = 1'b1;
          cmd.take_hit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/dqs_datapath.sv =====
// Datapath for the deque with search: entry memory, front pointer,
// entry count, search walker and result registers. Depends on dqs_pkg.
`default_nettype none

module dqs_datapath
  import dqs_pkg::*;
#(
  parameter int DEPTH = DQS_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dqs_cmd_t           cmd,
  input  wire logic signed [31:0] value_in,
  output dqs_sts_t                sts,
  output logic                    done,
  output logic signed [31:0]      value_out,
  output logic                    found,
  output logic [1:0]              status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

  logic [31:0]    mem [DEPTH];
  logic [31:0]    rd_data;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [AW:0]    back_sum;
  logic [AW-1:0]  back_addr;
  logic [AW-1:0]  front_dec;
  logic [AW-1:0]  front_inc;
  logic [AW-1:0]  ptr_inc;

  logic [AW-1:0]  front;
  logic [CW-1:0]  count;
  logic [AW-1:0]  ptr;
  logic [CW-1:0]  remaining;
  logic [31:0]    key;
  logic           cmp_vld;
  logic           hit;

  assign back_sum  = (AW + 1)'(front) + (AW + 1)'(count);
  assign back_addr = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
  assign front_dec = (front == '0) ? LAST : front - AW'(1);
  assign front_inc = (front == LAST) ? '0 : front + AW'(1);
  assign ptr_inc   = (ptr == LAST) ? '0 : ptr + AW'(1);
  assign wr_addr   = cmd.push_front ? front_dec : back_addr;
  assign rd_addr   = cmd.srch_run ? ptr : front;

  always_ff @(posedge clk) begin
    if (cmd.push_back || cmd.push_front) begin
      mem[wr_addr] <= value_in;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (cmd.push_back) begin
        count <= count + CW'(1);
      end
      if (cmd.push_front) begin
        front <= front_dec;
        count <= count + CW'(1);
      end
      if (cmd.pop_front) begin
        front <= front_inc;
        count <= count - CW'(1);
      end
      if (cmd.pop_back) begin
        count <= count - CW'(1);
      end
    end
  end

  // walk from front: issue one read a cycle, compare in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (cmd.srch_load) begin
      ptr       <= front;
      remaining <= count;
      key       <= value_in;
      cmp_vld   <= 1'b0;
    end else if (cmd.srch_run && (remaining != '0)) begin
      ptr       <= ptr_inc;
      remaining <= remaining - CW'(1);
      cmp_vld   <= 1'b1;
    end else begin
      cmp_vld <= 1'b0;
    end
  end

  assign hit = cmp_vld && (rd_data == key);

  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CW'(DEPTH));
  assign sts.srch_done = hit || (cmp_vld && (remaining == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      value_out <= cmd.take_rd ? rd_data : '0;
      found     <= cmd.take_hit && hit;
      status    <= cmd.res_status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/deque_with_search.sv =====
// Top level of the deque with search: controller plus datapath.
// Depends on dqs_pkg, dqs_ctrl and dqs_datapath.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+---------------------------
//   word in  | func, value_in             | taken when start & !busy
//   word out | value_out, found, status   | one-cycle strobe on done
//
// Pushes, drop from back and refused or empty words: result in the cycle
// after acceptance, next word may follow at once.
// Pop front: registered memory read, then state S_POP. Search: the walk
// over the stored entries goes through one read port.
// Reset empties the queue by clearing front and count; no memory clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module deque_with_search
  import dqs_pkg::*;
#(
  parameter int DEPTH = DQS_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         func,
  input  wire logic signed [31:0] value_in,
  output logic                    done,
  output logic signed [31:0]      value_out,
  output logic                    found,
  output logic [1:0]              status
);

  dqs_cmd_t cmd;
  dqs_sts_t sts;

  dqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dqs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value_in  (value_in),
    .sts       (sts),
    .done      (done),
    .value_out (value_out),
    .found     (found),
    .status    (status)
  );

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted word neither finished nor started work");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while controller busy");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> ((value_out == '0) && (status == ST_OK)))
    else $error("search hit with nonzero value or bad status");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    sts.full |-> !sts.empty)
    else $error("queue reported full and empty together");

endmodule

`default_nettype wire
